FILE: src/rsvng_pkg.sv
package rsvng_pkg;

   localparam int CW         = 32;
   localparam int DW         = 34;
   localparam int VW         = 48;
   localparam int NW         = 16;
   localparam int TW         = 16;
   localparam int QW         = 15;
   localparam int SW         = 64;
   localparam int CUT_BITS   = 23;
   localparam int UNIT_BITS  = 30;
   localparam int ONE_Q14    = 16384;
   localparam int Q14_SHIFT  = 14;
   localparam int AXIS_ROUND = 8192;

   typedef struct packed {
      logic signed [CW-1:0] edge_a_x;
      logic signed [CW-1:0] edge_a_y;
      logic signed [CW-1:0] edge_a_z;
      logic signed [CW-1:0] edge_b_x;
      logic signed [CW-1:0] edge_b_y;
      logic signed [CW-1:0] edge_b_z;
      logic                 last_point;
   } req_payload_type;

   typedef struct packed {
      logic signed [CW-1:0] vert_x;
      logic signed [CW-1:0] vert_y;
      logic signed [CW-1:0] vert_z;
      logic signed [NW-1:0] norm_x;
      logic signed [NW-1:0] norm_y;
      logic signed [NW-1:0] norm_z;
      logic [2:0]           corner;
      logic                 last_of_run;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SETUP,
      ST_CLOAD,
      ST_CUTA,
      ST_CUTB,
      ST_XMUL,
      ST_XACC,
      ST_ULOAD,
      ST_UCUT,
      ST_SQMUL,
      ST_SQACC,
      ST_SQRT,
      ST_DIVLOAD,
      ST_DIV,
      ST_DIVEND,
      ST_JOBEND,
      ST_AXMUL,
      ST_AXACC,
      ST_OUT,
      ST_EMITEND
   } state_type;

   typedef enum logic [1:0] {
      JOB_N,
      JOB_AXIS,
      JOB_B
   } job_type;

   function automatic logic [VW-1:0] vmag(input logic signed [VW-1:0] v);
      return v[VW-1] ? VW'(-v) : VW'(v);
   endfunction

   function automatic logic signed [VW-1:0] vhalf(input logic signed [VW-1:0] v);
      logic [VW-1:0] m;
      m = vmag(v) >> 1;
      return v[VW-1] ? -signed'(m) : signed'(m);
   endfunction

   function automatic logic vbig(input logic signed [VW-1:0] v, input int bits);
      return vmag(v) >= (VW'(1) << bits);
   endfunction

   function automatic logic [1:0] cross_ai(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0: r = 2'd1;
         3'd1: r = 2'd2;
         3'd2: r = 2'd2;
         3'd3: r = 2'd0;
         3'd4: r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] cross_bi(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0: r = 2'd2;
         3'd1: r = 2'd1;
         3'd2: r = 2'd0;
         3'd3: r = 2'd2;
         3'd4: r = 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: src/rsvng_req_if.sv
interface rsvng_req_if;
   import rsvng_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/rsvng_rsp_if.sv
interface rsvng_rsp_if;
   import rsvng_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/ribbon_strip_vertex_normal_gen.sv
// A pair is worked through vector cuts, a shared 32x32 multiplier, a 32-step square root and
// 15-step divides before its vertices are emitted; a transaction runs 0-2 pairs, and output
// can stall on rsp ready.
// Throughput: one transaction at a time; req ready only while the sequencer is idle.
// Reset (synchronous, active high): thickness, stored pairs and offset axis clear, rsp invalid.
module ribbon_strip_vertex_normal_gen (
   input  logic                       clock,
   input  logic                       reset,
   rsvng_req_if.sink                  req_if,
   rsvng_rsp_if.source                rsp_if,
   input  logic                       csr_wr_en,
   input  logic [rsvng_pkg::TW-1:0]   csr_wr_data
);
   import rsvng_pkg::*;

   state_type            state_ff, state_in;
   job_type              job_ff, job_in;
   logic [TW-1:0]        thick_ff, thick_in;
   logic signed [CW-1:0] prev_ff [6];
   logic signed [CW-1:0] prev_in [6];
   logic signed [CW-1:0] cur_ff [6];
   logic signed [CW-1:0] cur_in [6];
   logic signed [CW-1:0] np_ff [6];
   logic signed [CW-1:0] np_in [6];
   logic                 have_prev_ff, have_prev_in;
   logic                 have_cur_ff, have_cur_in;
   logic                 last_ff, last_in;
   logic                 sel_ff, sel_in;
   logic signed [CW-1:0] axis_ff [3];
   logic signed [CW-1:0] axis_in [3];
   logic signed [DW-1:0] t_ff [3];
   logic signed [DW-1:0] t_in [3];
   logic signed [DW-1:0] s_ff [3];
   logic signed [DW-1:0] s_in [3];
   logic signed [DW-1:0] f_ff [3];
   logic signed [DW-1:0] f_in [3];
   logic signed [VW-1:0] va_ff [3];
   logic signed [VW-1:0] va_in [3];
   logic signed [VW-1:0] vb_ff [3];
   logic signed [VW-1:0] vb_in [3];
   logic signed [VW-1:0] vc_ff [3];
   logic signed [VW-1:0] vc_in [3];
   logic signed [NW-1:0] n_ff [3];
   logic signed [NW-1:0] n_in [3];
   logic signed [NW-1:0] b_ff [3];
   logic signed [NW-1:0] b_in [3];
   logic signed [NW-1:0] ures_ff [3];
   logic signed [NW-1:0] ures_in [3];
   logic signed [SW-1:0] prod_ff, prod_in;
   logic signed [CW-1:0] mul_a, mul_b;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [SW-1:0]        x_ff, x_in;
   logic [SW-1:0]        r_ff, r_in;
   logic [SW-1:0]        bit_ff, bit_in;
   logic [VW-1:0]        rem_ff, rem_in;
   logic [QW-1:0]        quot_ff, quot_in;
   logic [3:0]           dstep_ff, dstep_in;
   logic [2:0]           cnt_ff, cnt_in;
   rsp_payload_type      rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic signed [CW-1:0] pt [6];
   logic signed [CW-1:0] prv [6];
   logic                 has_prv, has_nxt;
   logic                 thick_mode;
   logic [1:0]           ci;
   logic [SW-1:0]        sq_try;
   logic [VW-1:0]        div_comp;
   logic [VW-1:0]        div_num;
   logic [QW-1:0]        q_clip;
   logic [CW-1:0]        ax_m;
   logic [NW-1:0]        ures_mag;
   logic                 big_a, big_b, big_u;
   logic                 use_b_pt, add_ax, use_side, neg_n;
   logic [2:0]           last_corner;
   logic                 out_go;
   logic signed [NW-1:0] nv [3];
   logic signed [CW-1:0] pos [3];

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         pt[i]  = sel_ff ? np_ff[i] : cur_ff[i];
         prv[i] = sel_ff ? cur_ff[i] : prev_ff[i];
      end
      has_prv    = sel_ff ? have_cur_ff : have_prev_ff;
      has_nxt    = !sel_ff;
      thick_mode = (thick_ff != '0);
      ci         = cnt_ff[1:0];
      big_a      = vbig(va_ff[0], CUT_BITS) || vbig(va_ff[1], CUT_BITS) ||
                   vbig(va_ff[2], CUT_BITS);
      big_b      = vbig(vb_ff[0], CUT_BITS) || vbig(vb_ff[1], CUT_BITS) ||
                   vbig(vb_ff[2], CUT_BITS);
      big_u      = vbig(va_ff[0], UNIT_BITS) || vbig(va_ff[1], UNIT_BITS) ||
                   vbig(va_ff[2], UNIT_BITS);
      sq_try     = r_ff + bit_ff;
      div_comp   = VW'(r_ff[CW-1:0]) << dstep_ff;
      div_num    = (vmag(va_ff[ci]) << Q14_SHIFT) + VW'(r_ff[CW-1:1]);
      q_clip     = (quot_ff > QW'(ONE_Q14)) ? QW'(ONE_Q14) : quot_ff;
      ax_m       = (prod_ff[CW-1:0] + CW'(AXIS_ROUND)) >> Q14_SHIFT;
      ures_mag   = ures_ff[ci][NW-1] ? NW'(-ures_ff[ci]) : NW'(ures_ff[ci]);

      if (thick_mode) begin
         use_b_pt    = cnt_ff[1];
         add_ax      = cnt_ff[2];
         use_side    = cnt_ff[0];
         neg_n       = cnt_ff[0] ? cnt_ff[1] : cnt_ff[2];
         last_corner = 3'd7;
      end else begin
         use_b_pt    = cnt_ff[0];
         add_ax      = 1'b0;
         use_side    = 1'b0;
         neg_n       = 1'b0;
         last_corner = 3'd1;
      end
      for (int i = 0; i < 3; i++) begin
         nv[i]  = use_side ? b_ff[i] : n_ff[i];
         nv[i]  = neg_n ? -nv[i] : nv[i];
         pos[i] = (use_b_pt ? pt[i+3] : pt[i]) + (add_ax ? axis_ff[i] : CW'(0));
      end
      out_go = !rsp_valid_ff || rsp_if.ready;

      case (state_ff)
         ST_XMUL: begin
            mul_a = va_ff[cross_ai(cnt_ff)][CW-1:0];
            mul_b = vb_ff[cross_bi(cnt_ff)][CW-1:0];
         end
         ST_SQMUL: begin
            mul_a = va_ff[ci][CW-1:0];
            mul_b = va_ff[ci][CW-1:0];
         end
         ST_AXMUL: begin
            mul_a = CW'(ures_mag);
            mul_b = CW'(thick_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      thick_in     = csr_wr_en ? csr_wr_data : thick_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      np_in        = np_ff;
      have_prev_in = have_prev_ff;
      have_cur_in  = have_cur_ff;
      last_in      = last_ff;
      sel_in       = sel_ff;
      axis_in      = axis_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      f_in         = f_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      vc_in        = vc_ff;
      n_in         = n_ff;
      b_in         = b_ff;
      ures_in      = ures_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      x_in         = x_ff;
      r_in         = r_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      dstep_in     = dstep_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      req_if.ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               np_in[0] = req_if.payload.edge_a_x;
               np_in[1] = req_if.payload.edge_a_y;
               np_in[2] = req_if.payload.edge_a_z;
               np_in[3] = req_if.payload.edge_b_x;
               np_in[4] = req_if.payload.edge_b_y;
               np_in[5] = req_if.payload.edge_b_z;
               last_in  = req_if.payload.last_point;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (have_cur_ff) begin
               sel_in   = 1'b0;
               state_in = ST_SETUP;
            end else if (last_ff) begin
               sel_in   = 1'b1;
               state_in = ST_SETUP;
            end else begin
               cur_in      = np_ff;
               have_cur_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_SETUP: begin
            for (int i = 0; i < 3; i++) begin
               t_in[i] = (has_prv ? DW'(pt[i]) - DW'(prv[i]) : DW'(0)) +
                         (has_nxt ? DW'(np_ff[i]) - DW'(pt[i]) : DW'(0));
               s_in[i] = DW'(pt[i+3]) - DW'(pt[i]);
               f_in[i] = DW'(np_ff[i]) - DW'(pt[i]);
            end
            job_in   = JOB_N;
            state_in = ST_CLOAD;
         end
         ST_CLOAD: begin
            for (int i = 0; i < 3; i++) begin
               if (job_ff == JOB_AXIS) begin
                  va_in[i] = VW'(s_ff[i]);
                  vb_in[i] = VW'(f_ff[i]);
               end else begin
                  va_in[i] = VW'(t_ff[i]);
                  vb_in[i] = VW'(s_ff[i]);
               end
            end
            state_in = ST_CUTA;
         end
         ST_CUTA: begin
            if (big_a) begin
               for (int i = 0; i < 3; i++) va_in[i] = vhalf(va_ff[i]);
            end else begin
               state_in = ST_CUTB;
            end
         end
         ST_CUTB: begin
            if (big_b) begin
               for (int i = 0; i < 3; i++) vb_in[i] = vhalf(vb_ff[i]);
            end else begin
               cnt_in   = '0;
               state_in = ST_XMUL;
            end
         end
         ST_XMUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_XACC;
         end
         ST_XACC: begin
            if (!cnt_ff[0]) begin
               vc_in[cnt_ff[2:1]] = signed'(prod_ff[VW-1:0]);
            end else begin
               vc_in[cnt_ff[2:1]] = vc_ff[cnt_ff[2:1]] - signed'(prod_ff[VW-1:0]);
            end
            if (cnt_ff == 3'd5) begin
               state_in = ST_ULOAD;
            end else begin
               cnt_in   = cnt_ff + 3'd1;
               state_in = ST_XMUL;
            end
         end
         ST_ULOAD: begin
            for (int i = 0; i < 3; i++) begin
               va_in[i] = (job_ff == JOB_B) ? VW'(s_ff[i]) : vc_ff[i];
            end
            sum_in   = '0;
            cnt_in   = '0;
            state_in = ST_UCUT;
         end
         ST_UCUT: begin
            if (big_u) begin
               for (int i = 0; i < 3; i++) va_in[i] = vhalf(va_ff[i]);
            end else begin
               state_in = ST_SQMUL;
            end
         end
         ST_SQMUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_SQACC;
         end
         ST_SQACC: begin
            sum_in = sum_ff + SW'(prod_ff);
            if (cnt_ff == 3'd2) begin
               x_in     = sum_ff + SW'(prod_ff);
               r_in     = '0;
               bit_in   = SW'(1) << (SW - 2);
               cnt_in   = '0;
               state_in = ST_SQRT;
            end else begin
               cnt_in   = cnt_ff + 3'd1;
               state_in = ST_SQMUL;
            end
         end
         ST_SQRT: begin
            if (x_ff >= sq_try) begin
               x_in = x_ff - sq_try;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) state_in = ST_DIVLOAD;
         end
         ST_DIVLOAD: begin
            rem_in   = div_num;
            quot_in  = '0;
            dstep_in = 4'(QW - 1);
            state_in = (r_ff == '0) ? ST_DIVEND : ST_DIV;
         end
         ST_DIV: begin
            if (rem_ff >= div_comp) begin
               rem_in            = rem_ff - div_comp;
               quot_in[dstep_ff] = 1'b1;
            end
            if (dstep_ff == '0) begin
               state_in = ST_DIVEND;
            end else begin
               dstep_in = dstep_ff - 4'd1;
            end
         end
         ST_DIVEND: begin
            ures_in[ci] = va_ff[ci][VW-1] ? -signed'(NW'(q_clip)) : signed'(NW'(q_clip));
            if (cnt_ff == 3'd2) begin
               state_in = ST_JOBEND;
            end else begin
               cnt_in   = cnt_ff + 3'd1;
               state_in = ST_DIVLOAD;
            end
         end
         ST_JOBEND: begin
            cnt_in = '0;
            case (job_ff)
               JOB_N: begin
                  n_in = ures_ff;
                  if (has_nxt) begin
                     job_in   = JOB_AXIS;
                     state_in = ST_CLOAD;
                  end else if (thick_mode) begin
                     job_in   = JOB_B;
                     state_in = ST_ULOAD;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
               JOB_AXIS: begin
                  state_in = ST_AXMUL;
               end
               default: begin
                  b_in     = ures_ff;
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_AXMUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_AXACC;
         end
         ST_AXACC: begin
            axis_in[ci] = ures_ff[ci][NW-1] ? -signed'(ax_m) : signed'(ax_m);
            if (cnt_ff == 3'd2) begin
               cnt_in = '0;
               if (thick_mode) begin
                  job_in   = JOB_B;
                  state_in = ST_ULOAD;
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               cnt_in   = cnt_ff + 3'd1;
               state_in = ST_AXMUL;
            end
         end
         ST_OUT: begin
            if (out_go) begin
               rsp_in.vert_x      = pos[0];
               rsp_in.vert_y      = pos[1];
               rsp_in.vert_z      = pos[2];
               rsp_in.norm_x      = nv[0];
               rsp_in.norm_y      = nv[1];
               rsp_in.norm_z      = nv[2];
               rsp_in.corner      = cnt_ff;
               rsp_in.last_of_run = (cnt_ff == last_corner) && (sel_ff || !last_ff);
               rsp_valid_in       = 1'b1;
               if (cnt_ff == last_corner) begin
                  state_in = ST_EMITEND;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         end
         ST_EMITEND: begin
            if (!sel_ff) begin
               if (last_ff) begin
                  sel_in   = 1'b1;
                  state_in = ST_SETUP;
               end else begin
                  prev_in      = cur_ff;
                  have_prev_in = 1'b1;
                  cur_in       = np_ff;
                  have_cur_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               for (int i = 0; i < 6; i++) begin
                  prev_in[i] = '0;
                  cur_in[i]  = '0;
               end
               for (int i = 0; i < 3; i++) axis_in[i] = '0;
               have_prev_in = 1'b0;
               have_cur_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_N;
         thick_ff     <= '0;
         have_prev_ff <= 1'b0;
         have_cur_ff  <= 1'b0;
         last_ff      <= 1'b0;
         sel_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            prev_ff[i] <= '0;
            cur_ff[i]  <= '0;
         end
         for (int i = 0; i < 3; i++) axis_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         thick_ff     <= thick_in;
         have_prev_ff <= have_prev_in;
         have_cur_ff  <= have_cur_in;
         last_ff      <= last_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         cur_ff       <= cur_in;
         axis_ff      <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      np_ff    <= np_in;
      t_ff     <= t_in;
      s_ff     <= s_in;
      f_ff     <= f_in;
      va_ff    <= va_in;
      vb_ff    <= vb_in;
      vc_ff    <= vc_in;
      n_ff     <= n_in;
      b_ff     <= b_in;
      ures_ff  <= ures_in;
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      x_ff     <= x_in;
      r_ff     <= r_in;
      bit_ff   <= bit_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      dstep_ff <= dstep_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

`ifndef ASSERT_OFF
   a_prev_needs_cur: assert property (@(posedge clock) disable iff (reset)
      have_prev_ff |-> have_cur_ff)
      else $error("previous pair held without a current pair");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVEND) |-> (quot_ff <= QW'(ONE_Q14)))
      else $error("unit component quotient above one");

   a_sqrt_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> $onehot(bit_ff))
      else $error("square root step bit lost");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.norm_x >= -16'sd16384) && (rsp_ff.norm_x <= 16'sd16384))
      else $error("normal x out of range");
`endif

endmodule
